/* sv/plu_pkg.sv */
package plu_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam int TREE_FANIN = 8;

	typedef logic signed [31:0] elem_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] position;
		elem_t      value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		elem_t      read_value;
		logic [7:0] list_length;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_ctrl_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	function automatic int tree_nodes(input int n, input int lvl);
		int k;
		k = n;
		for (int i = 0; i < lvl; i++) begin
			k = (k + TREE_FANIN - 1) / TREE_FANIN;
		end
		return k;
	endfunction

	function automatic int tree_levels(input int n);
		int k;
		int lv;
		k = n;
		lv = 0;
		for (int i = 0; i < 16; i++) begin
			if (k > 1) begin
				k = (k + TREE_FANIN - 1) / TREE_FANIN;
				lv++;
			end
		end
		return lv;
	endfunction

endpackage

/* sv/plu_cell.sv */
module plu_cell #(
	parameter int IDX = 0,
	parameter int PW  = 9
) (
	input  logic                clk,
	input  plu_pkg::cell_ctrl_t ctrl,
	input  logic [PW-1:0]       pos0,
	input  plu_pkg::elem_t      left,
	input  plu_pkg::elem_t      right,
	input  plu_pkg::elem_t      ins_value,
	output plu_pkg::elem_t      q,
	output plu_pkg::elem_t      rd
);
	import plu_pkg::*;

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	elem_t data_q;
	logic  at_pos;
	logic  above_pos;

	assign at_pos    = (pos0 == MY_IDX);
	assign above_pos = (pos0 < MY_IDX);

	always_ff @(posedge clk) begin
		if (ctrl.ins && above_pos) begin
			data_q <= left;
		end else if (ctrl.ins && at_pos) begin
			data_q <= ins_value;
		end else if (ctrl.del && (at_pos || above_pos)) begin
			data_q <= right;
		end
	end

	assign q  = data_q;
	assign rd = (ctrl.rd && at_pos) ? data_q : '0;

endmodule

/* sv/plu_or_tree.sv */
module plu_or_tree #(
	parameter int N = 128
) (
	input  logic           clk,
	input  plu_pkg::elem_t d [N],
	output plu_pkg::elem_t q
);
	import plu_pkg::*;

	localparam int LEVELS = tree_levels(N);

	elem_t lvl [1:LEVELS][N];

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		for (genvar j = 0; j < tree_nodes(N, l); j++) begin : g_node
			elem_t acc;
			always_comb begin
				acc = '0;
				for (int c = 0; c < TREE_FANIN; c++) begin
					if (TREE_FANIN * j + c < tree_nodes(N, l - 1)) begin
						if (l == 1) begin
							acc = acc | d[TREE_FANIN * j + c];
						end else begin
							acc = acc | lvl[(l > 1) ? l - 1 : 1][TREE_FANIN * j + c];
						end
					end
				end
			end
			always_ff @(posedge clk) begin
				lvl[l][j] <= acc;
			end
		end
	end

	assign q = lvl[LEVELS][0];

endmodule

/* sv/positional_list_insert_delete_unit.sv */
// Ordered list of signed 32-bit values held in a row of CAPACITY cells, with insert,
// delete and read at a 1-based position. Insert and delete shift the cells at and above
// the position in parallel, each from its neighbour, so these, the unused operation code
// and rejected inserts and deletes register their beat on acceptance. A read, in range
// or not, goes through a registered OR tree of fan-in 8 across the cells, whose result
// is then registered as its beat. One item is in flight at a time; the next is accepted
// as soon as the current one has finished and the result holding slot is free, even
// while a result still waits on the output. The cell contents are not cleared at reset;
// only the length and the control and valid state are, so no clearing pass is needed.
module positional_list_insert_delete_unit #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  plu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output plu_pkg::rsp_t rsp
);
	import plu_pkg::*;

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int PW     = ((CW > 8) ? CW : 8) + 1;
	localparam int LEVELS = tree_levels(CAPACITY);
	localparam int LW     = $clog2(LEVELS + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [LW-1:0] wait_q;
	logic [1:0]    rd_status_q;
	logic [7:0]    rd_len_q;
	rsp_t          out_q, hold_q;
	logic          out_v_q, hold_v_q;

	logic          accept;
	logic          take;
	logic          complete;
	rsp_t          res;
	rsp_t          res_now;
	cell_ctrl_t    ctrl;
	logic [PW-1:0] pos_e, cnt_e, pos0, len_e;
	logic          ins_range_ok, range_ok, full;
	elem_t         tree_q;

	elem_t cell_q  [CAPACITY];
	elem_t cell_rd [CAPACITY];

	assign req_ready = (state_q == S_IDLE) && !hold_v_q;
	assign accept    = req_valid && req_ready;
	assign take      = out_v_q && rsp_ready;

	assign pos_e        = PW'(req.position);
	assign cnt_e        = PW'(count_q);
	assign pos0         = pos_e - PW'(1);
	assign ins_range_ok = (pos_e != '0) && (pos_e <= cnt_e + PW'(1));
	assign range_ok     = (pos_e != '0) && (pos_e <= cnt_e);
	assign full         = (cnt_e == PW'(CAPACITY));
	assign len_e        = PW'(count_d);

	always_comb begin
		ctrl    = '0;
		count_d = count_q;
		res_now = '0;
		case (req.operation)
			OP_INSERT: begin
				if (!ins_range_ok) begin
					res_now.status = STAT_RANGE;
				end else if (full) begin
					res_now.status = STAT_FULL;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (!range_ok) begin
					res_now.status = STAT_RANGE;
				end else begin
					ctrl.del = accept;
					count_d  = count_q - CW'(1);
				end
			end
			OP_READ: begin
				if (!range_ok) begin
					res_now.status = STAT_RANGE;
				end else begin
					ctrl.rd = accept;
				end
			end
			default: begin
				res_now.status = STAT_OK;
			end
		endcase
		res_now.list_length = len_e[7:0];
	end

	always_comb begin
		state_d  = state_q;
		complete = 1'b0;
		res      = res_now;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.operation == OP_READ) begin
						state_d = S_READ;
					end else begin
						complete = 1'b1;
					end
				end
			end
			S_READ: begin
				res.status      = rd_status_q;
				res.read_value  = tree_q;
				res.list_length = rd_len_q;
				if (wait_q == '0) begin
					complete = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= count_d;
				wait_q  <= LW'(LEVELS - 1);
			end else if (wait_q != '0) begin
				wait_q <= wait_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_status_q <= res_now.status;
			rd_len_q    <= res_now.list_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (complete) begin
				if (!out_v_q || take) begin
					out_v_q <= 1'b1;
				end else begin
					hold_v_q <= 1'b1;
				end
			end else if (take) begin
				out_v_q  <= hold_v_q;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			if (!out_v_q || take) begin
				out_q <= res;
			end else begin
				hold_q <= res;
			end
		end else if (take && hold_v_q) begin
			out_q <= hold_q;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		plu_cell #(
			.IDX(k),
			.PW (PW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.pos0     (pos0),
			.left     (cell_q[(k == 0) ? 0 : k - 1]),
			.right    (cell_q[(k == CAPACITY - 1) ? k : k + 1]),
			.ins_value(req.value),
			.q        (cell_q[k]),
			.rd       (cell_rd[k])
		);
	end

	plu_or_tree #(
		.N(CAPACITY)
	) u_tree (
		.clk(clk),
		.d  (cell_rd),
		.q  (tree_q)
	);

endmodule

/* sv/plu_checker.sv */
module plu_checker #(
	parameter int CAPACITY = 128
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input plu_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input plu_pkg::rsp_t rsp
);
	import plu_pkg::*;

	localparam logic [7:0] CAP_LEN = 8'(CAPACITY);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat dropped or changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	a_rsp_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == STAT_OK) || (rsp.status == STAT_RANGE)
			|| (rsp.status == STAT_FULL))
		else $error("unknown status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_OK) |-> rsp.read_value == '0)
		else $error("rejected operation returned a value");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_FULL) |-> rsp.list_length == CAP_LEN)
		else $error("full status with length below capacity");

endmodule

bind positional_list_insert_delete_unit plu_checker #(
	.CAPACITY(CAPACITY)
) u_plu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
